// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by go_back_n_sender_top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/gbn_pkg.sv =====
// shared types and constants for the go-back-n sender
// no dependencies
package gbn_pkg;

    localparam int SEQ_W          = 16;
    localparam int SUM_W          = 13;
    localparam int CHK_W          = 18;
    localparam int ACK_CHK_W      = 19;
    localparam int WIN_W          = 7;
    localparam int ACT_W          = 2;
    localparam int STORE_DEPTH_DEF = 256;
    localparam int MAX_WINDOW_DEF  = 64;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd8;

    typedef enum logic [ACT_W-1:0] {
        ACT_NEW     = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_EMPTY,
        RES_OVF,
        RES_ACK,
        RES_PKT
    } res_sel_t;

    typedef struct packed {
        logic [ACT_W-1:0]            action;
        logic signed [SUM_W-1:0]     msg_payload_sum;
        logic [SEQ_W-1:0]            ack_num;
        logic [SEQ_W-1:0]            ack_seq_num;
        logic signed [SUM_W-1:0]     ack_payload_sum;
        logic signed [ACK_CHK_W-1:0] ack_checksum;
    } evt_item_t;

    typedef struct packed {
        logic     latch;
        logic     store_msg;
        logic     rewind;
        logic     read_mem;
        res_sel_t load;
    } gbn_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             store_full;
        logic             allowed;
        logic             more;
        logic             out_free;
    } gbn_sts_t;

endpackage

// ===== hw/rtl/gbn_if.sv =====
// valid/ready channel interfaces for events in and results out
// depends on gbn_pkg
interface gbn_in_if import gbn_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [ACT_W-1:0]            action;
    logic signed [SUM_W-1:0]     msg_payload_sum;
    logic [SEQ_W-1:0]            ack_num;
    logic [SEQ_W-1:0]            ack_seq_num;
    logic signed [SUM_W-1:0]     ack_payload_sum;
    logic signed [ACK_CHK_W-1:0] ack_checksum;

    modport source (
        output valid, action, msg_payload_sum, ack_num, ack_seq_num,
               ack_payload_sum, ack_checksum,
        input  ready
    );
    modport sink (
        input  valid, action, msg_payload_sum, ack_num, ack_seq_num,
               ack_payload_sum, ack_checksum,
        output ready
    );
endinterface

interface gbn_out_if import gbn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    send_valid;
    logic [SEQ_W-1:0]        send_seq;
    logic signed [CHK_W-1:0] send_checksum;
    logic                    timer_start;
    logic                    timer_stop;
    logic                    overflow;
    logic                    last;

    modport source (
        output valid, send_valid, send_seq, send_checksum, timer_start,
               timer_stop, overflow, last,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_seq, send_checksum, timer_start,
               timer_stop, overflow, last,
        output ready
    );
endinterface

// ===== hw/rtl/go_back_n_sender_top.sv =====
// an ack, overflow or undefined-action beat is loaded from the exec state once the output slot is free
// a new message or timeout with nothing to send puts out an empty beat from the check state
// a send burst puts out packets one by one, checking the window and reading the store before each
// a busy output slot stalls any beat; a new event is taken only once the control is back in idle
// reset clears sequence numbers, message count and output valid and sets the window to 8; the store is not cleared
// depends on gbn_pkg, gbn_if, gbn_ctrl, gbn_datapath and assert_macros.svh
`include "assert_macros.svh"
module go_back_n_sender_top import gbn_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [WIN_W-1:0] cfg_wdata,
    gbn_in_if.sink           evt,
    gbn_out_if.source        rslt
);

    gbn_cmd_t  cmd;
    gbn_sts_t  sts;
    evt_item_t item;

    assign item.action          = evt.action;
    assign item.msg_payload_sum = evt.msg_payload_sum;
    assign item.ack_num         = evt.ack_num;
    assign item.ack_seq_num     = evt.ack_seq_num;
    assign item.ack_payload_sum = evt.ack_payload_sum;
    assign item.ack_checksum    = evt.ack_checksum;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt.valid),
        .in_ready (evt.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbn_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .rslt      (rslt)
    );

    // a packet beat never carries a stop or overflow flag
    `ASSERT_IMP(a_pkt_flags, clk, rst_n, rslt.valid && rslt.send_valid, !rslt.overflow && !rslt.timer_stop)
    // an overflow beat closes its event
    `ASSERT_IMP(a_ovf_last, clk, rst_n, rslt.valid && rslt.overflow, rslt.last)
    // busy after an event beat is taken
    `ASSERT_NXT(a_busy, clk, rst_n, evt.valid && evt.ready, !evt.ready)
    // results are loaded only when the output slot is free
    `ASSERT_IMP(a_load_free, clk, rst_n, cmd.load != RES_NONE, sts.out_free)

endmodule

// ===== hw/rtl/gbn_ctrl.sv =====
// sequencing state machine of the go-back-n sender
// depends on gbn_pkg; drives commands into gbn_datapath
module gbn_ctrl import gbn_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  gbn_sts_t sts,
    output gbn_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    assign in_ready = ready_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.latch     = 1'b0;
        cmd.store_msg = 1'b0;
        cmd.rewind    = 1'b0;
        cmd.read_mem  = 1'b0;
        cmd.load      = RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.action)
                    ACT_NEW:
                    begin
                        if (!sts.store_full)
                        begin
                            cmd.store_msg = 1'b1;
                            state_next    = S_CHECK;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.load   = RES_OVF;
                            state_next = S_IDLE;
                        end
                    end
                    ACT_ACK:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.load   = RES_ACK;
                            state_next = S_IDLE;
                        end
                    end
                    ACT_TIMEOUT:
                    begin
                        cmd.rewind = 1'b1;
                        state_next = S_CHECK;
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.load   = RES_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_CHECK:
            begin
                if (sts.allowed)
                begin
                    cmd.read_mem = 1'b1;
                    state_next   = S_EMIT;
                end
                else if (sts.out_free)
                begin
                    cmd.load   = RES_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = RES_PKT;
                    state_next = sts.more ? S_CHECK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

// ===== hw/rtl/gbn_datapath.sv =====
// sequence registers, payload-sum store and result register
// depends on gbn_pkg and gbn_if; commanded by gbn_ctrl
module gbn_datapath import gbn_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [WIN_W-1:0] cfg_wdata,
    input  evt_item_t        item,
    input  gbn_cmd_t         cmd,
    output gbn_sts_t         sts,
    gbn_out_if.source        rslt
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int TOT_W  = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int LIM_W  = SEQ_W + 1;

    logic [WIN_W-1:0]        window_reg;
    logic [SEQ_W-1:0]        base_reg, next_reg;
    logic [TOT_W-1:0]        total_reg;
    logic [CNT_W-1:0]        cnt_reg;
    evt_item_t               item_reg;
    logic [SUM_W-1:0]        mem [STORE_DEPTH];
    logic [SUM_W-1:0]        rd_reg;

    logic                    out_valid_reg;
    logic                    send_valid_reg;
    logic [SEQ_W-1:0]        send_seq_reg;
    logic signed [CHK_W-1:0] send_chk_reg;
    logic                    tstart_reg, tstop_reg, ovf_reg, last_reg;

    logic [CMP_W-1:0]        win_eff;
    logic [LIM_W-1:0]        limit;
    logic [LIM_W-1:0]        total_cmp;
    logic [SEQ_W-1:0]        next_inc;
    logic [CNT_W:0]          cnt_inc;
    logic                    allowed, more, out_free;
    logic [SEQ_W-1:0]        ack_base;
    logic signed [ACK_CHK_W-1:0] ack_expect;
    logic                    ack_ok;
    logic signed [CHK_W-1:0] pkt_chk;

    assign win_eff = (CMP_W'(window_reg) > CMP_W'(MAX_WINDOW)) ?
                     CMP_W'(MAX_WINDOW) : CMP_W'(window_reg);
    assign limit     = {1'b0, base_reg} + LIM_W'(win_eff);
    assign total_cmp = LIM_W'(total_reg);
    assign next_inc  = next_reg + 1'b1;
    assign cnt_inc   = {1'b0, cnt_reg} + 1'b1;

    assign allowed = (cnt_reg < CNT_W'(MAX_WINDOW)) && ({1'b0, next_reg} < limit)
                     && ({1'b0, next_reg} < total_cmp);
    assign more    = (cnt_inc < (CNT_W + 1)'(MAX_WINDOW)) && ({1'b0, next_inc} < limit)
                     && ({1'b0, next_inc} < total_cmp);

    assign out_free = !out_valid_reg || rslt.ready;

    assign ack_base   = item_reg.ack_num + 1'b1;
    assign ack_expect = ACK_CHK_W'(item_reg.ack_payload_sum)
                        + $signed({3'b000, item_reg.ack_seq_num})
                        + $signed({3'b000, item_reg.ack_num});
    assign ack_ok     = (ack_expect == item_reg.ack_checksum);

    assign pkt_chk = CHK_W'($signed(rd_reg)) + $signed({2'b00, next_reg});

    assign sts.action     = item_reg.action;
    assign sts.store_full = (total_reg == TOT_W'(STORE_DEPTH));
    assign sts.allowed    = allowed;
    assign sts.more       = more;
    assign sts.out_free   = out_free;

    assign rslt.valid         = out_valid_reg;
    assign rslt.send_valid    = send_valid_reg;
    assign rslt.send_seq      = send_seq_reg;
    assign rslt.send_checksum = send_chk_reg;
    assign rslt.timer_start   = tstart_reg;
    assign rslt.timer_stop    = tstop_reg;
    assign rslt.overflow      = ovf_reg;
    assign rslt.last          = last_reg;

    // payload-sum store
    always_ff @(posedge clk)
    begin
        if (cmd.store_msg)
        begin
            mem[total_reg[ADDR_W-1:0]] <= item_reg.msg_payload_sum;
        end
        if (cmd.read_mem)
        begin
            rd_reg <= mem[next_reg[ADDR_W-1:0]];
        end
    end

    // latched event and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        case (cmd.load)
            RES_EMPTY, RES_OVF:
            begin
                send_valid_reg <= 1'b0;
                send_seq_reg   <= '0;
                send_chk_reg   <= '0;
                tstart_reg     <= 1'b0;
                tstop_reg      <= 1'b0;
                ovf_reg        <= (cmd.load == RES_OVF);
                last_reg       <= 1'b1;
            end
            RES_ACK:
            begin
                send_valid_reg <= 1'b0;
                send_seq_reg   <= '0;
                send_chk_reg   <= '0;
                tstart_reg     <= ack_ok && (ack_base != next_reg);
                tstop_reg      <= ack_ok && (ack_base == next_reg);
                ovf_reg        <= 1'b0;
                last_reg       <= 1'b1;
            end
            RES_PKT:
            begin
                send_valid_reg <= 1'b1;
                send_seq_reg   <= next_reg;
                send_chk_reg   <= pkt_chk;
                tstart_reg     <= (base_reg == next_reg);
                tstop_reg      <= 1'b0;
                ovf_reg        <= 1'b0;
                last_reg       <= !more;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            base_reg      <= '0;
            next_reg      <= '0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (cmd.store_msg)
            begin
                total_reg <= total_reg + 1'b1;
                cnt_reg   <= '0;
            end
            if (cmd.rewind)
            begin
                next_reg <= base_reg;
                cnt_reg  <= '0;
            end
            if (cmd.load == RES_PKT)
            begin
                next_reg <= next_inc;
                cnt_reg  <= cnt_inc[CNT_W-1:0];
            end
            if (cmd.load == RES_ACK && ack_ok)
            begin
                base_reg <= ack_base;
            end
            if (cmd.load != RES_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rslt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
